[hdl/dmh_pkg.sv]
// ----------------------------------------------------------------------------
// dmh_pkg: shared types and constants
// Request, status and sequencer codes plus the fixed field widths of the
// d-ary min-heap priority queue.
// ----------------------------------------------------------------------------
package dmh_pkg;

    localparam int ID_W      = 10;
    localparam int ID_SPACE  = 1024;
    localparam int REQ_W     = 2;
    localparam int KEY_IN_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int ARITY_W   = 4;

    localparam logic [ARITY_W-1:0] ARITY_RST = 4'd4;
    localparam logic [ARITY_W-1:0] ARITY_MIN = 4'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DECR    = 2'd1,
        REQ_EXTRACT = 2'd2,
        REQ_PEEK    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_RAISE  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PM_RD,
        S_FIND_RD,
        S_FIND_CHK,
        S_UP_TEST,
        S_DIV_WAIT,
        S_UP_CMP,
        S_UP_PLACE,
        S_RT_RD,
        S_RT_CHK,
        S_LAST_CHK,
        S_DN_START,
        S_DN_RD,
        S_DN_CMP,
        S_DN_STEP,
        S_DONE
    } t_state;

endpackage

[hdl/dmh_if.sv]
// ----------------------------------------------------------------------------
// dmh_if: channel interfaces
// Valid/ready channels for configuration, requests and results.
// ----------------------------------------------------------------------------
interface dmh_cfg_if import dmh_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ARITY_W-1:0] arity;

    modport source (output valid, output arity, input ready);
    modport sink   (input valid, input arity, output ready);
endinterface

interface dmh_req_if import dmh_pkg::*;;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     item_id;
    logic [KEY_IN_W-1:0] new_key;

    modport source (output valid, output req_type, output item_id, output new_key,
                    input ready);
    modport sink   (input valid, input req_type, input item_id, input new_key,
                    output ready);
endinterface

interface dmh_rsp_if import dmh_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     out_id;
    logic [KEY_IN_W-1:0] out_key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output out_id, output out_key, output status,
                    output count, input ready);
    modport sink   (input valid, input out_id, input out_key, input status,
                    input count, output ready);
endinterface

[hdl/dary_min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// dary_min_heap_priority_queue: d-ary min-heap with decrease-key
// Heap of item ids keyed by unsigned keys, with an id-to-slot map, run by a
// sequencer over single-port memories and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beat when
//  i_cfg    in   arity                            valid & ready
//  i_req    in   req_type, item_id, new_key       valid & ready
//  o_rsp    out  out_id, out_key, status, count   valid & ready
//
//  One request at a time; i_req.ready is high only in idle.
//  Each sift-up level finds the parent via the iterative divider; each
//  sift-down level does one slot memory read per child.
//  The result sits in an output register; the next request is taken while it
//  waits. Synchronous active-low reset empties the heap; memories are not
//  cleared.
// ----------------------------------------------------------------------------
module dary_min_heap_priority_queue import dmh_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_BITS  = 32,
    parameter int MAX_ARITY = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dmh_cfg_if.sink      i_cfg,
    dmh_req_if.sink      i_req,
    dmh_rsp_if.source    o_rsp
);
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(MAX_ARITY + 1);
    localparam int CXW = SW + AW + 1;
    localparam int EW  = ID_W + KEY_BITS;

    t_state              r_state, n_state;
    logic [ARITY_W-1:0]  r_arity;
    logic [CW-1:0]       r_count;
    t_req                r_req;
    logic [ID_W-1:0]     r_id;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_s;
    logic [SW-1:0]       r_p;
    logic [CXW-1:0]      r_c;
    logic [CXW-1:0]      r_end;
    logic [CXW-1:0]      r_best;
    logic [ID_W-1:0]     r_bid;
    logic [KEY_BITS-1:0] r_bkey;
    logic [ID_W-1:0]     r_oid;
    logic [KEY_BITS-1:0] r_okey;
    t_status             r_st;

    logic                r_ovalid;
    logic [ID_W-1:0]     r_out_id;
    logic [KEY_IN_W-1:0] r_out_key;
    t_status             r_out_st;
    logic [COUNT_W-1:0]  r_out_count;

    logic [EW-1:0]       r_slot_mem [CAPACITY];
    logic [EW-1:0]       r_slot_q;
    logic [SW-1:0]       r_pm_mem [ID_SPACE];
    logic [SW-1:0]       r_pm_q;

    logic                slot_we, slot_re, pm_we, pm_re;
    logic [SW-1:0]       slot_wa, slot_ra;
    logic [EW-1:0]       slot_wd;
    logic [ID_W-1:0]     pm_wa;
    logic [SW-1:0]       pm_wd;

    logic [AW-1:0]       d_eff;
    logic                div_start, div_done;
    logic [SW-1:0]       div_quot;
    logic [ID_W-1:0]     q_id;
    logic [KEY_BITS-1:0] q_key;
    logic                found;
    logic                full;
    logic [CXW-1:0]      first_c;
    logic                scan_more;
    logic                out_load;
    logic                req_beat;

    always_comb begin
        if (r_arity < ARITY_MIN) begin
            d_eff = AW'(2);
        end else if (int'(r_arity) > MAX_ARITY) begin
            d_eff = AW'(MAX_ARITY);
        end else begin
            d_eff = AW'(r_arity);
        end
    end

    assign q_id      = r_slot_q[EW-1:KEY_BITS];
    assign q_key     = r_slot_q[KEY_BITS-1:0];
    assign found     = (CW'(r_pm_q) < r_count) && (q_id == r_id);
    assign full      = (r_count == CW'(CAPACITY));
    assign first_c   = CXW'(d_eff) * CXW'(r_s) + CXW'(1);
    assign scan_more = (r_c < r_end) && (r_c < CXW'(r_count));
    assign out_load  = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);
    assign req_beat  = i_req.valid && i_req.ready;

    dmh_div #(.NUM_W(SW), .DEN_W(AW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_s - 1'b1),
        .i_den   (d_eff),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_beat) begin
                    if (t_req'(i_req.req_type) == REQ_INSERT ||
                        t_req'(i_req.req_type) == REQ_DECR) begin
                        n_state = S_PM_RD;
                    end else begin
                        n_state = S_RT_RD;
                    end
                end
            end
            S_PM_RD:    n_state = S_FIND_RD;
            S_FIND_RD:  n_state = S_FIND_CHK;
            S_FIND_CHK: begin
                if (found) begin
                    n_state = (r_key > q_key) ? S_DONE : S_UP_TEST;
                end else if (r_req == REQ_INSERT && !full) begin
                    n_state = S_UP_TEST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP_TEST:  n_state = (r_s == '0) ? S_UP_PLACE : S_DIV_WAIT;
            S_DIV_WAIT: n_state = div_done ? S_UP_CMP : S_DIV_WAIT;
            S_UP_CMP:   n_state = (q_key > r_key) ? S_UP_TEST : S_UP_PLACE;
            S_UP_PLACE: n_state = S_DONE;
            S_RT_RD:    n_state = (r_count == '0) ? S_DONE : S_RT_CHK;
            S_RT_CHK:   n_state = (r_req == REQ_PEEK) ? S_DONE : S_LAST_CHK;
            S_LAST_CHK: n_state = S_DN_START;
            S_DN_START: n_state = S_DN_RD;
            S_DN_RD:    n_state = scan_more ? S_DN_CMP : S_DN_STEP;
            S_DN_CMP:   n_state = S_DN_RD;
            S_DN_STEP:  n_state = (r_best == CXW'(r_s)) ? S_DONE : S_DN_START;
            S_DONE:     n_state = out_load ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory and divider control
    always_comb begin
        slot_we   = 1'b0;
        slot_wa   = r_s;
        slot_wd   = {r_id, r_key};
        slot_re   = 1'b0;
        slot_ra   = r_pm_q;
        pm_we     = 1'b0;
        pm_wa     = r_id;
        pm_wd     = r_s;
        pm_re     = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_PM_RD:    pm_re = 1'b1;
            S_FIND_RD:  slot_re = 1'b1;
            S_UP_TEST:  div_start = (r_s != '0);
            S_DIV_WAIT: begin
                slot_re = div_done;
                slot_ra = div_quot;
            end
            S_UP_CMP: begin
                if (q_key > r_key) begin
                    slot_we = 1'b1;
                    slot_wd = r_slot_q;
                    pm_we   = 1'b1;
                    pm_wa   = q_id;
                end
            end
            S_UP_PLACE: begin
                slot_we = 1'b1;
                pm_we   = 1'b1;
            end
            S_RT_RD: begin
                slot_re = (r_count != '0);
                slot_ra = '0;
            end
            S_RT_CHK: begin
                slot_re = (r_req == REQ_EXTRACT);
                slot_ra = SW'(r_count - 1'b1);
            end
            S_DN_RD: begin
                slot_re = scan_more;
                slot_ra = r_c[SW-1:0];
            end
            S_DN_STEP: begin
                slot_we = 1'b1;
                pm_we   = 1'b1;
                if (r_best != CXW'(r_s)) begin
                    slot_wd = {r_bid, r_bkey};
                    pm_wa   = r_bid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            r_slot_q <= r_slot_mem[slot_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_pm_mem[pm_wa] <= pm_wd;
        end
        if (pm_re) begin
            r_pm_q <= r_pm_mem[r_id];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (req_beat) begin
                    r_req  <= t_req'(i_req.req_type);
                    r_id   <= i_req.item_id;
                    r_key  <= KEY_BITS'(i_req.new_key);
                    r_oid  <= '0;
                    r_okey <= '0;
                    r_st   <= ST_OK;
                end
            end
            S_FIND_CHK: begin
                if (found) begin
                    if (r_key > q_key) begin
                        r_st <= ST_RAISE;
                    end
                    r_s <= r_pm_q;
                end else if (r_req == REQ_INSERT && !full) begin
                    r_s <= SW'(r_count);
                end else begin
                    r_st <= (r_req == REQ_INSERT) ? ST_FULL : ST_EMPTY;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_p <= div_quot;
                end
            end
            S_UP_CMP: begin
                if (q_key > r_key) begin
                    r_s <= r_p;
                end
            end
            S_RT_RD: begin
                if (r_count == '0) begin
                    r_st <= ST_EMPTY;
                end
            end
            S_RT_CHK: begin
                r_oid  <= q_id;
                r_okey <= q_key;
            end
            S_LAST_CHK: begin
                r_id  <= q_id;
                r_key <= q_key;
                r_s   <= '0;
            end
            S_DN_START: begin
                r_c    <= first_c;
                r_end  <= first_c + CXW'(d_eff);
                r_best <= CXW'(r_s);
                r_bid  <= r_id;
                r_bkey <= r_key;
            end
            S_DN_CMP: begin
                if (q_key < r_bkey) begin
                    r_best <= r_c;
                    r_bid  <= q_id;
                    r_bkey <= q_key;
                end
                r_c <= r_c + CXW'(1);
            end
            S_DN_STEP: begin
                r_s <= r_best[SW-1:0];
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_arity  <= ARITY_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_arity <= i_cfg.arity;
            end
            // same decision order as the sequencer, so both agree on a new insert
            if (r_state == S_FIND_CHK) begin
                if (found) begin
                    r_count <= r_count;
                end else if (r_req == REQ_INSERT && !full) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (r_state == S_RT_CHK && r_req == REQ_EXTRACT) begin
                r_count <= r_count - 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id    <= r_oid;
            r_out_key   <= KEY_IN_W'(r_okey);
            r_out_st    <= r_st;
            r_out_count <= COUNT_W'(r_count);
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.out_id  = r_out_id;
    assign o_rsp.out_key = r_out_key;
    assign o_rsp.status  = r_out_st;
    assign o_rsp.count   = r_out_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("heap count beyond capacity");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("heap count jumped");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out_st != ST_OK) |-> (r_out_id == '0 && r_out_key == '0))
        else $error("failed request carries data");
    a_count_hold_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RT_CHK && r_req == REQ_PEEK) |=> $stable(r_count))
        else $error("peek changed count");
`endif
endmodule

[hdl/dmh_div.sv]
// ----------------------------------------------------------------------------
// dmh_div: iterative divider
// Restoring division, one quotient bit per cycle; gives the parent slot.
// ----------------------------------------------------------------------------
module dmh_div #(
    parameter int NUM_W = 10,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], q_bit};
                r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != CNT_W'(NUM_W)) |-> (r_rem < r_den))
        else $error("remainder out of range");
`endif
endmodule
